FILE: rtl/core/sbc_pkg.sv
// Shared types, constants and character map functions for the six-bit
// character pack codec. No dependencies.
`default_nettype none
package sbc_pkg;

  localparam int unsigned CharsPerWord = 5;
  localparam int unsigned CodeBits     = 6;
  localparam int unsigned WordBits     = CharsPerWord * CodeBits;
  localparam int unsigned HeldBits     = WordBits - CodeBits;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [CodeBits-1:0] SPACE_CODE = 6'd52;
  localparam logic [CodeBits-1:0] BAD_CODE   = 6'd63;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] LOWER_OFFS = 8'h47;

  typedef enum logic {
    KIND_ENC = 1'b0,
    KIND_DEC = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [WordBits-1:0]   word;
    logic                  last;
  } entry_t;

  function automatic logic [CodeBits-1:0] enc_char(input logic [7:0] c);
    logic [CodeBits-1:0] r;
    begin
      r = BAD_CODE;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
        r = CodeBits'(c - CH_UPPER_A);
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
        r = CodeBits'(c - CH_LOWER_A + 8'd26);
      end else begin
        case (c)
          CH_SPACE:   r = 6'd52;
          CH_PERIOD:  r = 6'd53;
          CH_QUOTE:   r = 6'd54;
          CH_SEMI:    r = 6'd55;
          CH_COLON:   r = 6'd56;
          CH_NEWLINE: r = 6'd57;
          CH_BANG:    r = 6'd58;
          default:    r = BAD_CODE;
        endcase
      end
      return r;
    end
  endfunction

  function automatic logic [7:0] dec_code(input logic [CodeBits-1:0] k);
    logic [7:0] r;
    begin
      r = 8'h00;
      if (k <= 6'd25) begin
        r = 8'(k) + CH_UPPER_A;
      end else if (k <= 6'd51) begin
        r = 8'(k) + LOWER_OFFS;
      end else begin
        case (k)
          6'd52:    r = CH_SPACE;
          6'd53:    r = CH_PERIOD;
          6'd54:    r = CH_QUOTE;
          6'd55:    r = CH_SEMI;
          6'd56:    r = CH_COLON;
          6'd57:    r = CH_NEWLINE;
          6'd58:    r = CH_BANG;
          BAD_CODE: r = CH_AT;
          default:  r = 8'h00;
        endcase
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/six_bit_char_pack_codec.sv
// Top level of the six-bit character pack codec: front end, work queue and
// back end. Depends on sbc_pkg, sbc_front, sbc_queue and sbc_back.
// An accepted item is written into the work queue, then loaded into the
// single output register. Throughput: encode takes one byte per cycle while
// the queue has room; decode gives one character per cycle while output is taken.
// Reset clears direction (encode), the held codes and count, queue and output.
`default_nettype none
module six_bit_char_pack_codec import sbc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic         cfg_data_i,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [7:0]   in_char_i,
  input  wire logic [31:0]  in_word_i,
  input  wire logic         end_of_message_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [29:0]       packed_word_o,
  output logic [7:0]        char_out_o,
  output logic              last_of_run_o
);

  logic   push, pop, q_full, q_empty;
  entry_t push_data, head;

  assign cfg_ready_o = 1'b1;

  sbc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_char_i        (in_char_i),
    .in_word_i        (in_word_i),
    .end_of_message_i (end_of_message_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  sbc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  sbc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_word_o (packed_word_o),
    .char_out_o    (char_out_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
`default_nettype wire

FILE: rtl/core/sbc_front.sv
// Front end: takes input items, holds the direction register, gathers
// encode codes into groups and pushes work entries. Depends on sbc_pkg.
`default_nettype none
module sbc_front import sbc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  input  wire logic         cfg_data_i,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [7:0]   in_char_i,
  input  wire logic [31:0]  in_word_i,
  input  wire logic         end_of_message_i,
  input  wire logic         q_full_i,
  output logic              push_o,
  output entry_t            push_data_o
);

  logic                direction_q;
  logic [2:0]          slot_q, slot_d;
  logic [HeldBits-1:0] held_q, held_d;
  logic                accept;
  logic [CodeBits-1:0] code;
  logic [2:0]          cnt;
  logic                group_done;
  logic [WordBits-1:0] enc_word;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign code       = enc_char(in_char_i);

  always_comb begin
    cnt = (slot_q > 3'(CharsPerWord - 1)) ? 3'(CharsPerWord) : slot_q + 3'd1;
    group_done = (cnt == 3'(CharsPerWord)) || end_of_message_i;
    case (cnt)
      3'd1:    enc_word = {code, SPACE_CODE, SPACE_CODE, SPACE_CODE, SPACE_CODE};
      3'd2:    enc_word = {held_q[5:0], code, SPACE_CODE, SPACE_CODE, SPACE_CODE};
      3'd3:    enc_word = {held_q[11:0], code, SPACE_CODE, SPACE_CODE};
      3'd4:    enc_word = {held_q[17:0], code, SPACE_CODE};
      default: enc_word = {held_q, code};
    endcase
  end

  always_comb begin
    slot_d      = slot_q;
    held_d      = held_q;
    push_o      = 1'b0;
    push_data_o = '{kind: KIND_ENC, word: enc_word, last: end_of_message_i};
    if (accept) begin
      if (direction_q) begin
        push_o      = 1'b1;
        push_data_o = '{kind: KIND_DEC, word: in_word_i[WordBits-1:0], last: 1'b0};
      end else if (group_done) begin
        push_o = 1'b1;
        slot_d = '0;
        held_d = '0;
      end else begin
        slot_d = cnt;
        held_d = {held_q[HeldBits-CodeBits-1:0], code};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
      slot_q      <= '0;
      held_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        direction_q <= cfg_data_i;
      end
      slot_q <= slot_d;
      held_q <= held_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sbc_queue.sv
// Short work queue between front and back ends.
// Depends on sbc_pkg.
`default_nettype none
module sbc_queue import sbc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  entry_t    push_data_i,
  input  wire logic pop_i,
  output entry_t    head_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  entry_t             mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;

  assign full_o  = (count_q == CntBits'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(QueueDepth))
    else $error("queue count overflow");

endmodule
`default_nettype wire

FILE: rtl/core/sbc_back.sv
// Back end: drains work entries to the output register, one result item per
// cycle unless stalled; decode entries give five chars. Depends on sbc_pkg.
`default_nettype none
module sbc_back import sbc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  entry_t                    head_i,
  input  wire logic                 empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [WordBits-1:0]       packed_word_o,
  output logic [7:0]                char_out_o,
  output logic                      last_of_run_o
);

  logic                out_valid_q;
  logic [WordBits-1:0] packed_word_q;
  logic [7:0]          char_out_q;
  logic                last_q;
  logic [2:0]          idx_q, idx_d;
  logic                load;
  logic                last_char;
  logic [CodeBits-1:0] code;

  assign load      = !empty_i && (!out_valid_q || out_ready_i);
  assign last_char = (idx_q == 3'(CharsPerWord - 1));

  always_comb begin
    case (idx_q)
      3'd0:    code = head_i.word[29:24];
      3'd1:    code = head_i.word[23:18];
      3'd2:    code = head_i.word[17:12];
      3'd3:    code = head_i.word[11:6];
      default: code = head_i.word[5:0];
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    idx_d = idx_q;
    if (load) begin
      if (head_i.kind == KIND_ENC) begin
        pop_o = 1'b1;
      end else if (last_char) begin
        pop_o = 1'b1;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (head_i.kind == KIND_ENC) begin
        packed_word_q <= head_i.word;
        char_out_q    <= 8'h00;
        last_q        <= head_i.last;
      end else begin
        packed_word_q <= '0;
        char_out_q    <= dec_code(code);
        last_q        <= last_char;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_word_o = packed_word_q;
  assign char_out_o    = char_out_q;
  assign last_of_run_o = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 3'(CharsPerWord - 1))
    else $error("character index out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 3'd0 |-> (!empty_i && head_i.kind == KIND_DEC))
    else $error("split in progress without decode entry at head");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && packed_word_q != '0) |-> char_out_q == 8'h00)
    else $error("encode item carries a character");

endmodule
`default_nettype wire
